// File: rtl/hash_join_probe_assert.svh
// assertion macros for the hash join probe block
// expects clk and rst_n in the scope where they are used
`ifndef HASH_JOIN_PROBE_ASSERT_SVH
`define HASH_JOIN_PROBE_ASSERT_SVH

// checked only outside reset
`define HJP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hash_join_probe assertion failed");

// checked at every edge, reset included
`define HJP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hash_join_probe assertion failed in reset");

`endif

// File: rtl/hjp_pkg.sv
// shared types and constants for the hash join probe block
// no dependencies
package hjp_pkg;

  localparam int BuildDepthDef    = 512;
  localparam int ProbeCountBitsDef = 20;
  localparam int ProbePosW        = 20;
  localparam int BuildPosW        = 9;
  localparam int KeyW             = 32;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_PROBE = 2'd2;

  typedef struct packed {
    logic [1:0]             req_type;
    logic signed [KeyW-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [ProbePosW-1:0]   probe_position;
    logic [BuildPosW-1:0]   build_position;
    logic signed [KeyW-1:0] match_value;
  } out_item_t;

  // item moving down the cell chain
  typedef struct packed {
    logic                   valid;
    logic                   is_load;
    logic                   hit;
    logic [ProbePosW-1:0]   probe_pos;
    logic signed [KeyW-1:0] key;
  } tok_t;

endpackage

// File: rtl/hjp_cell.sv
// one cell of the compare chain: holds one build key
// depends on hjp_pkg
module hjp_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 10,
  parameter int POS_W = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  hjp_pkg::tok_t     tok_in,
  input  logic [CNT_W-1:0]  cnt_in,
  input  logic [POS_W-1:0]  pos_in,
  output hjp_pkg::tok_t     tok_out,
  output logic [CNT_W-1:0]  cnt_out,
  output logic [POS_W-1:0]  pos_out
);
  import hjp_pkg::*;

  logic signed [KeyW-1:0] key_r;
  tok_t                   tok_r, tok_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   wr_en, hit;

  // load writes the cell whose index equals the count seen at entry
  assign wr_en = tok_in.valid && tok_in.is_load && (cnt_in == CNT_W'(IDX));
  // probe only compares cells below its entry count
  assign hit   = tok_in.valid && !tok_in.is_load && (CNT_W'(IDX) < cnt_in)
                 && (key_r == tok_in.key);

  always_comb begin
    tok_nxt = tok_in;
    pos_nxt = pos_in;
    if (hit) begin
      tok_nxt.hit = 1'b1;
      pos_nxt     = POS_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (en && wr_en) begin
      key_r <= tok_in.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
      cnt_r <= cnt_in;
      pos_r <= pos_nxt;
    end
  end

  assign tok_out = tok_r;
  assign cnt_out = cnt_r;
  assign pos_out = pos_r;

endmodule

// File: rtl/hash_join_probe.sv
// hash join probe engine: a chain of key cells with an output register
// depends on hjp_pkg and hjp_cell
//
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/in_stall   | req_type, key
//   out     | output    | out_valid/out_stall | probe_position, build_position, match_value
//
// unless held, a new item is taken every cycle; loads and probes move one cell a cycle
// a probe result passes every cell register and then the output register
// clear resets the input counters, unused codes touch nothing; neither leaves a trace
// reset clears counters and valid bits; stored keys need no reset
// the whole chain holds while a result waits on out_stall
module hash_join_probe #(
  parameter int BUILD_DEPTH      = hjp_pkg::BuildDepthDef,
  parameter int PROBE_COUNT_BITS = hjp_pkg::ProbeCountBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hjp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hjp_pkg::out_item_t out_data
);
  import hjp_pkg::*;

  localparam int CntW = $clog2(BUILD_DEPTH + 1);
  localparam int PosW = $clog2(BUILD_DEPTH);

  logic [CntW-1:0]             build_count_r, build_count_nxt;
  logic [PROBE_COUNT_BITS-1:0] probe_count_r, probe_count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  out_item_t                   out_data_r, out_data_nxt;
  logic                        en, accept;

  // links between cells
  tok_t            tok [0:BUILD_DEPTH];
  logic [CntW-1:0] cnt [0:BUILD_DEPTH];
  logic [PosW-1:0] pos [0:BUILD_DEPTH];

  // chain moves unless a result is waiting and stalled
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  // counters at the head of the chain
  always_comb begin
    build_count_nxt = build_count_r;
    probe_count_nxt = probe_count_r;
    if (accept) begin
      case (in_data.req_type)
        REQ_CLEAR: begin
          build_count_nxt = '0;
          probe_count_nxt = '0;
        end
        REQ_LOAD: begin
          // loads past capacity are dropped
          if (build_count_r < CntW'(BUILD_DEPTH)) begin
            build_count_nxt = build_count_r + 1'b1;
          end
        end
        REQ_PROBE: begin
          probe_count_nxt = probe_count_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // item entering the chain carries the counts seen at entry
  assign tok[0].valid     = accept && (in_data.req_type == REQ_LOAD ||
                                       in_data.req_type == REQ_PROBE);
  assign tok[0].is_load   = (in_data.req_type == REQ_LOAD);
  assign tok[0].hit       = 1'b0;
  assign tok[0].probe_pos = ProbePosW'(probe_count_r);
  assign tok[0].key       = in_data.key;
  assign cnt[0] = build_count_r;
  assign pos[0] = '0;

  // cells run from build position zero upward, so the last hit is the highest
  for (genvar i = 0; i < BUILD_DEPTH; i++) begin : g_cell
    hjp_cell #(
      .IDX  (i),
      .CNT_W(CntW),
      .POS_W(PosW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .tok_in (tok[i]),
      .cnt_in (cnt[i]),
      .pos_in (pos[i]),
      .tok_out(tok[i+1]),
      .cnt_out(cnt[i+1]),
      .pos_out(pos[i+1])
    );
  end

  // output register fed by the chain tail; only probe hits become results
  always_comb begin
    out_valid_nxt               = tok[BUILD_DEPTH].valid && !tok[BUILD_DEPTH].is_load
                                  && tok[BUILD_DEPTH].hit;
    out_data_nxt.probe_position = tok[BUILD_DEPTH].probe_pos;
    out_data_nxt.build_position = BuildPosW'(pos[BUILD_DEPTH]);
    out_data_nxt.match_value    = tok[BUILD_DEPTH].key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      build_count_r <= '0;
      probe_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      build_count_r <= build_count_nxt;
      probe_count_r <= probe_count_nxt;
      if (en) begin
        out_valid_r <= out_valid_nxt;
        out_data_r  <= out_data_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/hjp_checker.sv
// port-level checks for the hash join probe block, bound to the top level
// depends on hjp_pkg and hash_join_probe_assert.svh
`include "hash_join_probe_assert.svh"

module hjp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input hjp_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input hjp_pkg::out_item_t out_data
);

  // no result straight out of reset
  `HJP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid)
  // a stalled result holds
  `HJP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))
  // a stalled input item holds
  `HJP_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(in_data))
  // input only backs up behind a stalled result
  `HJP_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall)
  // a taken result with nothing behind it frees the input next cycle
  `HJP_ASSERT(a_stall_release, out_valid && !out_stall |=> !in_stall || out_valid)

endmodule

bind hash_join_probe hjp_checker u_hjp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// File: tb/sv/tb_hash_join_probe.sv
// self-checking testbench for hash_join_probe: directed and random join traffic
// checked against an in-bench join predictor
// depends on hjp_pkg and the hash_join_probe rtl
module tb_hash_join_probe;
  import hjp_pkg::*;

  localparam int DEPTH       = BuildDepthDef;
  localparam int PCNT_BITS   = ProbeCountBitsDef;
  localparam int MAX_CYCLES  = 200000;
  localparam int RAND_ITEMS  = 500;
  localparam int QUIET_ITEMS = 100;
  // ring of owed matches, larger than anything the chain can hold
  localparam int OWED_DEPTH  = 2048;

  // request code with no meaning, the block must ignore it
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  hash_join_probe #(
    .BUILD_DEPTH      (DEPTH),
    .PROBE_COUNT_BITS (PCNT_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // join state as the bench sees it: build keys, their count, next probe position
  logic [KeyW-1:0]      build_keys [DEPTH];
  int                   build_cnt  = 0;
  logic [PCNT_BITS-1:0] probe_ctr  = '0;

  // matches still owed by the block, oldest at the read index
  out_item_t owed_matches [OWED_DEPTH];
  int        owed_wr = 0;
  int        owed_rd = 0;

  int errors     = 0;
  int cycle_cnt  = 0;
  int stall_left = 0;
  bit gaps_on    = 1'b0;
  bit stalls_on  = 1'b0;

  // apply one accepted item to the join state and queue the match it causes
  function automatic void predict_join(input in_item_t it);
    out_item_t hit;
    int        pos;
    pos = -1;
    case (it.req_type)
      REQ_CLEAR: begin
        // stored keys stay but are no longer compared
        build_cnt = 0;
        probe_ctr = '0;
      end
      REQ_LOAD: begin
        // a full table drops the load
        if (build_cnt < DEPTH) begin
          build_keys[build_cnt] = it.key;
          build_cnt++;
        end
      end
      REQ_PROBE: begin
        // the last equal key wins, like a map that overwrites
        for (int i = 0; i < build_cnt; i++) begin
          if (build_keys[i] == it.key) pos = i;
        end
        if (pos >= 0) begin
          hit.probe_position = ProbePosW'(probe_ctr);
          hit.build_position = BuildPosW'(pos);
          hit.match_value    = it.key;
          owed_matches[owed_wr % OWED_DEPTH] = hit;
          owed_wr++;
        end
        // wraps at the counter width
        probe_ctr = probe_ctr + 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  // a key currently in the table, or a random one when the table is empty
  function automatic logic [KeyW-1:0] stored_key();
    if (build_cnt == 0) return $urandom;
    return build_keys[$urandom_range(0, build_cnt - 1)];
  endfunction

  function automatic void check_field(input string name,
                                      input logic [KeyW-1:0] want,
                                      input logic [KeyW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // send one item, with an optional idle burst ahead of it; valid stays high
  // after acceptance so back-to-back items never drop it within one step
  task automatic send_item(input logic [1:0] req, input logic [KeyW-1:0] key);
    in_item_t it;
    it.req_type = req;
    it.key      = key;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      // junk on the bus while idle
      in_data  <= {2'($urandom), 32'($urandom)};
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_join(it);
  endtask

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (!stalls_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // every accepted match is checked against the oldest owed one
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_rd == owed_wr) begin
        errors++;
        $display("%0t unexpected match: expected none, actual %h", $time, out_data);
      end else begin
        want = owed_matches[owed_rd % OWED_DEPTH];
        owed_rd++;
        check_field("probe_position", KeyW'(want.probe_position),
                    KeyW'(out_data.probe_position));
        check_field("build_position", KeyW'(want.build_position),
                    KeyW'(out_data.build_position));
        check_field("match_value", want.match_value, out_data.match_value);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // key extremes, duplicates, misses, the ignored code and a clear
  task automatic test_corner_keys();
    send_item(REQ_CLEAR, 32'hFFFF_FFFF);
    // empty table: a miss that still takes probe position zero
    send_item(REQ_PROBE, 32'h1234_5678);
    send_item(REQ_LOAD, 32'h8000_0000);
    send_item(REQ_LOAD, 32'h7FFF_FFFF);
    send_item(REQ_LOAD, 32'hFFFF_FFFF);
    send_item(REQ_LOAD, 32'h0000_0000);
    send_item(REQ_LOAD, 32'hAAAA_AAAA);
    send_item(REQ_LOAD, 32'h5555_5555);
    // repeated key, the later position must be reported
    send_item(REQ_LOAD, 32'h0000_0000);
    send_item(REQ_PROBE, 32'h8000_0000);
    send_item(REQ_PROBE, 32'h7FFF_FFFF);
    send_item(REQ_PROBE, 32'hFFFF_FFFF);
    send_item(REQ_PROBE, 32'h0000_0000);
    send_item(REQ_PROBE, 32'hAAAA_AAAA);
    send_item(REQ_PROBE, 32'h5555_5555);
    send_item(REQ_PROBE, 32'h0000_0001);
    // ignored code must not load, count or match
    send_item(REQ_UNUSED, 32'h7FFF_FFFF);
    send_item(REQ_UNUSED, 32'h0000_0000);
    send_item(REQ_PROBE, 32'h7FFF_FFFF);
    // after a clear the old keys are gone and positions restart
    send_item(REQ_CLEAR, 32'h0000_0000);
    send_item(REQ_PROBE, 32'h8000_0000);
    send_item(REQ_LOAD, 32'h8000_0000);
    send_item(REQ_PROBE, 32'h8000_0000);
  endtask

  // fill every build position, then try loads past capacity
  task automatic test_table_full();
    send_item(REQ_CLEAR, $urandom);
    for (int i = 0; i < DEPTH; i++) send_item(REQ_LOAD, {16'hC3A5, 16'(i)});
    // dropped: a fresh key, a repeat of position 5 and zero
    send_item(REQ_LOAD, 32'hDEAD_0001);
    send_item(REQ_LOAD, {16'hC3A5, 16'd5});
    send_item(REQ_LOAD, 32'h0000_0000);
    send_item(REQ_PROBE, {16'hC3A5, 16'(DEPTH - 1)});
    send_item(REQ_PROBE, {16'hC3A5, 16'd0});
    send_item(REQ_PROBE, {16'hC3A5, 16'd5});
    send_item(REQ_PROBE, 32'hDEAD_0001);
    send_item(REQ_PROBE, 32'h0000_0000);
    for (int i = 0; i < 24; i++) send_item(REQ_PROBE, stored_key());
  endtask

  // a long run of probes against a small table, hits and misses mixed
  task automatic test_probe_burst();
    send_item(REQ_CLEAR, 32'h0000_0000);
    for (int i = 0; i < 4; i++) send_item(REQ_LOAD, $urandom);
    for (int i = 0; i < 40; i++)
      send_item(REQ_PROBE, ($urandom_range(0, 3) == 0) ? $urandom : stored_key());
  endtask

  // long mixed stream: mostly loads and probes, hit or miss, rare clears and junk codes
  task automatic test_random_mix();
    int              pick;
    logic [KeyW-1:0] key;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      // last stretch runs flat out on both sides
      if (n == RAND_ITEMS - QUIET_ITEMS) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: key = $urandom;
        // small keys repeat often, so duplicates pile up
        4, 5:       key = $urandom_range(0, 15);
        // zero, all ones and the two sign-boundary values
        6:          key = {1'($urandom), {31{1'($urandom)}}};
        default:    key = stored_key();
      endcase
      pick = $urandom_range(0, 199);
      if (pick == 0)      send_item(REQ_CLEAR, key);
      else if (pick < 4)  send_item(REQ_UNUSED, key);
      else if (pick < 80) send_item(REQ_LOAD, key);
      else                send_item(REQ_PROBE, key);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n    <= 1'b1;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_corner_keys();
    test_table_full();
    test_probe_burst();
    test_random_mix();
    in_valid <= 1'b0;
    // drain, then give the chain a full pass to expose stray matches
    while (owed_rd != owed_wr) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: hash_join_probe.f
+incdir+rtl
rtl/hjp_pkg.sv
rtl/hjp_cell.sv
rtl/hash_join_probe.sv
rtl/hjp_checker.sv
tb/sv/tb_hash_join_probe.sv
